>>> rtl/lmfe_pkg.sv
package lmfe_pkg;

   localparam int REQ_W  = 112;
   localparam int RSP_W  = 136;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [1:0] OP_POLL  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FORCE = 2'd2;

   localparam logic [3:0] ST_HOME      = 4'd0;
   localparam logic [3:0] ST_WAKE      = 4'd1;
   localparam logic [3:0] ST_WAKE_WAIT = 4'd2;
   localparam logic [3:0] ST_BREAK     = 4'd3;
   localparam logic [3:0] ST_SYNC      = 4'd4;
   localparam logic [3:0] ST_ID        = 4'd5;
   localparam logic [3:0] ST_TXD       = 4'd6;
   localparam logic [3:0] ST_RXD       = 4'd7;
   localparam logic [3:0] ST_TXCS      = 4'd8;
   localparam logic [3:0] ST_RXCS      = 4'd9;
   localparam logic [3:0] ST_READBACK  = 4'd10;
   localparam logic [3:0] ST_CS_FAIL   = 4'd11;
   localparam logic [3:0] ST_RB_FAIL   = 4'd12;
   localparam logic [3:0] ST_TO_FAIL   = 4'd13;
   localparam logic [3:0] ST_END       = 4'd14;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_DONE    = 3'd1;
   localparam logic [2:0] EV_CS_FAIL = 3'd2;
   localparam logic [2:0] EV_RB_FAIL = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;

   localparam logic [2:0] CSR_ENHANCED  = 3'd0;
   localparam logic [2:0] CSR_TO_TWO    = 3'd1;
   localparam logic [2:0] CSR_TO_FOUR   = 3'd2;
   localparam logic [2:0] CSR_TO_EIGHT  = 3'd3;
   localparam logic [2:0] CSR_SLEEP     = 3'd4;
   localparam logic [2:0] CSR_WAKE_WAIT = 3'd5;

   localparam logic [7:0]  SYNC_BYTE    = 8'h55;
   localparam logic [7:0]  CSUM_INV     = 8'hff;
   localparam logic [5:0]  ENH_ID_LIMIT = 6'd60;
   localparam logic [5:0]  ID_LEN2_MAX  = 6'h1f;
   localparam logic [5:0]  ID_LEN4_MAX  = 6'h2f;
   localparam logic [3:0]  LEN_TWO      = 4'd2;
   localparam logic [3:0]  LEN_FOUR     = 4'd4;
   localparam logic [3:0]  LEN_EIGHT    = 4'd8;
   localparam logic [15:0] TICK_MAX     = 16'hffff;

   // request payload, lowest field last
   typedef struct packed {
      logic        tx_ready;
      logic [7:0]  rx_byte;
      logic        rx_valid;
      logic        tick;
      logic [63:0] frame_data;
      logic [15:0] frame_period;
      logic [3:0]  frame_length;
      logic        frame_is_tx;
      logic [5:0]  frame_id;
      logic [2:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic [15:0] timing_errors;
      logic [15:0] readback_errors;
      logic [15:0] checksum_errors;
      logic [63:0] rx_frame_data;
      logic [2:0]  event_frame;
      logic [2:0]  event_code;
      logic [3:0]  machine_state;
      logic [7:0]  tx_byte;
      logic        tx_is_break;
      logic        tx_valid;
   } rsp_type;

   typedef struct packed {
      logic [63:0] data;
      logic [15:0] period;
      logic [3:0]  len;
      logic        is_tx;
      logic [5:0]  id;
   } row_type;

   typedef struct packed {
      logic        enhanced;
      logic [15:0] to_two;
      logic [15:0] to_four;
      logic [15:0] to_eight;
      logic [15:0] sleep;
      logic [15:0] wake_wait;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  state;
      logic [3:0]  ret;
      logic [7:0]  exp_rb;
      logic [3:0]  pos;
      logic [3:0]  alen;
      logic [7:0]  csum;
      logic [15:0] st_elapsed;
      logic        pend_flag;
      logic [7:0]  pend_val;
   } ctx_type;

   typedef struct packed {
      ctx_type     nxt;
      logic        tx_valid;
      logic        tx_brk;
      logic [7:0]  tx_byte;
      logic [2:0]  ev;
      logic [63:0] rx_data;
      logic        row_we;
      logic [63:0] row_data;
   } step_type;

   function automatic logic [7:0] protected_id(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

   function automatic logic [3:0] frame_len(input logic [5:0] id, input logic [3:0] setting);
      logic [3:0] r;
      if (setting == 4'd0) begin
         r = (id <= ID_LEN2_MAX) ? LEN_TWO : ((id <= ID_LEN4_MAX) ? LEN_FOUR : LEN_EIGHT);
      end else if (setting > LEN_EIGHT) begin
         r = LEN_EIGHT;
      end else begin
         r = setting;
      end
      return r;
   endfunction

   // carry-wrapped add
   function automatic logic [7:0] csum_add(input logic [7:0] c, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, c} + {1'b0, b};
      if (s > 9'd255) s = s - 9'd255;
      return s[7:0];
   endfunction

endpackage

>>> rtl/lmfe_ram.sv
module lmfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end

endmodule

>>> rtl/lmfe_step.sv
module lmfe_step import lmfe_pkg::*; (
   input  ctx_type  cur,
   input  row_type  row,
   input  cfg_type  cfg,
   input  logic     ready,
   input  logic     found,
   output step_type res
);

   always_comb begin
      ctx_type     n;
      logic [3:0]  s;
      logic [15:0] limit;
      logic [7:0]  pid;
      logic [7:0]  b;
      logic [7:0]  cs;
      logic [3:0]  pos1;
      logic [63:0] d;
      res   = '0;
      n     = cur;
      s     = cur.state;
      pid   = protected_id(row.id);
      pos1  = cur.pos + 4'd1;
      b     = row.data[{cur.pos[2:0], 3'b000} +: 8];
      d     = row.data;
      cs    = cur.csum;
      priority if (cur.alen == LEN_TWO)  limit = cfg.to_two;
      else if     (cur.alen == LEN_FOUR) limit = cfg.to_four;
      else                               limit = cfg.to_eight;

      // per-state timeout overrides the state for this step
      if (s >= ST_BREAK && s <= ST_READBACK && cur.st_elapsed >= limit) s = ST_TO_FAIL;
      n.state = s;

      unique case (s)
         ST_HOME: begin
            if (found) begin
               n.state      = (cur.st_elapsed >= cfg.sleep) ? ST_WAKE : ST_BREAK;
               n.pend_flag  = 1'b0;
               n.st_elapsed = '0;
            end
         end
         ST_WAKE: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_brk   = 1'b1;
               n.state      = ST_WAKE_WAIT;
               n.st_elapsed = '0;
            end
         end
         ST_WAKE_WAIT: begin
            if (cur.st_elapsed >= cfg.wake_wait) begin
               n.pend_flag  = 1'b0;
               n.state      = ST_BREAK;
               n.st_elapsed = '0;
            end
         end
         ST_BREAK: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_brk   = 1'b1;
               n.exp_rb     = '0;
               n.ret        = ST_SYNC;
               n.state      = ST_READBACK;
               n.st_elapsed = '0;
            end
         end
         ST_SYNC: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = SYNC_BYTE;
               n.exp_rb     = SYNC_BYTE;
               n.ret        = ST_ID;
               n.state      = ST_READBACK;
               n.st_elapsed = '0;
            end
         end
         ST_ID: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = pid;
               n.exp_rb     = pid;
               n.ret        = row.is_tx ? ST_TXD : ST_RXD;
               n.pos        = '0;
               n.csum       = (cfg.enhanced && pid[5:0] < ENH_ID_LIMIT) ? pid : 8'd0;
               n.state      = ST_READBACK;
               n.st_elapsed = '0;
            end
         end
         ST_TXD: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = b;
               n.exp_rb     = b;
               cs           = csum_add(cur.csum, b);
               n.pos        = pos1;
               if (pos1 >= cur.alen) begin
                  cs    = cs ^ CSUM_INV;
                  n.ret = ST_TXCS;
               end
               n.csum       = cs;
               n.state      = ST_READBACK;
               n.st_elapsed = '0;
            end
         end
         ST_RXD: begin
            if (cur.pend_flag) begin
               n.pend_flag = 1'b0;
               d[{cur.pos[2:0], 3'b000} +: 8] = cur.pend_val;
               res.row_we   = 1'b1;
               res.row_data = d;
               cs           = csum_add(cur.csum, cur.pend_val);
               n.pos        = pos1;
               if (pos1 >= cur.alen) begin
                  cs      = cs ^ CSUM_INV;
                  n.state = ST_RXCS;
               end
               n.csum       = cs;
               n.st_elapsed = '0;
            end
         end
         ST_TXCS: begin
            if (ready) begin
               res.tx_valid = 1'b1;
               res.tx_byte  = cur.csum;
               n.exp_rb     = cur.csum;
               n.ret        = ST_END;
               n.state      = ST_READBACK;
               n.st_elapsed = '0;
            end
         end
         ST_RXCS: begin
            if (cur.pend_flag) begin
               n.pend_flag  = 1'b0;
               n.state      = (cur.csum == cur.pend_val) ? ST_END : ST_CS_FAIL;
               n.st_elapsed = '0;
            end
         end
         ST_READBACK: begin
            if (cur.pend_flag) begin
               n.pend_flag = 1'b0;
               if (cur.pend_val == cur.exp_rb) begin
                  n.state      = cur.ret;
                  n.st_elapsed = '0;
               end else begin
                  n.state = ST_RB_FAIL;
               end
            end
         end
         ST_CS_FAIL: begin
            res.ev       = EV_CS_FAIL;
            n.state      = ST_HOME;
            n.st_elapsed = '0;
         end
         ST_RB_FAIL: begin
            res.ev       = EV_RB_FAIL;
            n.state      = ST_HOME;
            n.st_elapsed = '0;
         end
         ST_TO_FAIL: begin
            res.ev       = EV_TIMEOUT;
            n.state      = ST_HOME;
            n.st_elapsed = '0;
         end
         ST_END: begin
            res.ev       = EV_DONE;
            if (!row.is_tx) res.rx_data = row.data;
            n.state      = ST_HOME;
            n.st_elapsed = '0;
         end
         default: begin
            n.state = ST_HOME;
         end
      endcase
      res.nxt = n;
   end

endmodule

>>> rtl/lin_master_frame_engine.sv
// LIN master frame engine. Each request on the req_ channel is one step of the
// engine: an optional frame table write (op 1) or forced transfer (op 2),
// then a time tick, a received UART byte and the transmitter-ready flag are
// applied, and one protocol state is processed. Exactly one response follows
// each request on rsp_, carrying what to send on the bus, the new state, any
// frame event and the error totals. The frame table and the per-entry
// elapsed-tick counters live in two single-port-read RAMs with a registered
// read. A request passes from acceptance through the op, read and execute
// phases back to ready when no tick comes and the engine is busy with a
// frame; with a tick, or in the home state, a sweep phase comes first, in
// which the engine sweeps the elapsed RAM and the table RAM one entry per
// cycle to age the counters and pick the next frame. The response register
// lets a new request in while the previous response waits; a request only
// stalls at its final step if the prior response is still unclaimed. Entries
// read as zero until first written (per-entry valid bits), so no clearing
// pass runs after reset.
module lin_master_frame_engine import lmfe_pkg::*; #(
   parameter int NUM_FRAMES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [2:0] frame_index, [8:3] frame_id, [9] frame_is_tx, [13:10] frame_length,
   // [29:14] frame_period, [93:30] frame_data, [94] tick, [95] rx_valid,
   // [103:96] rx_byte, [104] tx_ready, rest zero
   input  logic [REQ_W-1:0]  req_tdata,
   // [1:0] op
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [0] tx_valid, [1] tx_is_break, [9:2] tx_byte, [13:10] machine_state,
   // [16:14] event_code, [19:17] event_frame, [83:20] rx_frame_data,
   // [99:84] checksum_errors, [115:100] readback_errors,
   // [131:116] timing_errors, rest zero
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int IW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW    = $clog2(NUM_FRAMES + 1);
   localparam int ROW_W = $bits(row_type);

   // request sequencer
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_OP    = 3'd1;  // table / force writes, tick, rx latch
   localparam logic [2:0] PH_SWEEP = 3'd2;  // age counters, pick next frame
   localparam logic [2:0] PH_RD    = 3'd3;  // read active entry
   localparam logic [2:0] PH_EXEC  = 3'd4;  // one protocol step, load response

   logic [2:0]            phase_ff, phase_in;
   req_type               req_ff, req_in;
   logic [1:0]            op_ff, op_in;
   cfg_type               cfg_ff, cfg_in;
   ctx_type               ctx_ff, ctx_in;
   logic [IW-1:0]         sel_ff, sel_in;
   logic                  found_ff, found_in;
   logic [CW-1:0]         rd_cnt_ff, rd_cnt_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [IW-1:0]         proc_idx_ff, proc_idx_in;
   logic [NUM_FRAMES-1:0] force_ff, force_in;
   logic [NUM_FRAMES-1:0] tbl_vld_ff, tbl_vld_in;
   logic [NUM_FRAMES-1:0] elp_vld_ff, elp_vld_in;
   logic [15:0]           cs_err_ff, cs_err_in;
   logic [15:0]           rb_err_ff, rb_err_in;
   logic [15:0]           to_err_ff, to_err_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_vld_ff, rsp_vld_in;

   logic                  tbl_we;
   logic [IW-1:0]         tbl_waddr, tbl_raddr;
   logic [ROW_W-1:0]      tbl_wdata, tbl_rdata;
   logic                  elp_we;
   logic [IW-1:0]         elp_waddr, elp_raddr;
   logic [15:0]           elp_wdata, elp_rdata;

   row_type               act_row, p_row, new_row;
   logic [15:0]           p_elp, p_inc;
   logic                  issue, can_pick, pick_force, pick_per, idx_ok;
   logic [IW-1:0]         req_idx;
   step_type              step;

   lmfe_ram #(.WIDTH(ROW_W), .DEPTH(NUM_FRAMES)) u_tbl (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   lmfe_ram #(.WIDTH(16), .DEPTH(NUM_FRAMES)) u_elp (
      .clock (clock),
      .we    (elp_we),
      .waddr (elp_waddr),
      .wdata (elp_wdata),
      .raddr (elp_raddr),
      .rdata (elp_rdata)
   );

   // active entry, never-written entries read as zero
   assign act_row = tbl_vld_ff[sel_ff] ? row_type'(tbl_rdata) : '0;

   lmfe_step u_step (
      .cur   (ctx_ff),
      .row   (act_row),
      .cfg   (cfg_ff),
      .ready (req_ff.tx_ready),
      .found (found_ff),
      .res   (step)
   );

   // sweep datapath: entry proc_idx_ff arrives from both RAMs
   assign p_row      = tbl_vld_ff[proc_idx_ff] ? row_type'(tbl_rdata) : '0;
   assign p_elp      = elp_vld_ff[proc_idx_ff] ? elp_rdata : '0;
   assign p_inc      = (req_ff.tick && p_elp != TICK_MAX) ? p_elp + 16'd1 : p_elp;
   assign can_pick   = (ctx_ff.state == ST_HOME) && !found_ff;
   assign pick_force = can_pick && force_ff[proc_idx_ff];
   assign pick_per   = can_pick && !force_ff[proc_idx_ff] && p_row.period != 16'd0 &&
                       p_inc >= p_row.period;
   assign issue      = rd_cnt_ff != CW'(NUM_FRAMES);

   assign idx_ok  = 32'(req_ff.frame_index) < NUM_FRAMES;
   assign req_idx = IW'(req_ff.frame_index);

   always_comb begin
      new_row.data   = req_ff.frame_data;
      new_row.period = req_ff.frame_period;
      new_row.len    = req_ff.frame_length;
      new_row.is_tx  = req_ff.frame_is_tx;
      new_row.id     = req_ff.frame_id;
   end

   always_comb begin
      phase_in    = phase_ff;
      req_in      = req_ff;
      op_in       = op_ff;
      cfg_in      = cfg_ff;
      ctx_in      = ctx_ff;
      sel_in      = sel_ff;
      found_in    = found_ff;
      rd_cnt_in   = rd_cnt_ff;
      proc_vld_in = proc_vld_ff;
      proc_idx_in = proc_idx_ff;
      force_in    = force_ff;
      tbl_vld_in  = tbl_vld_ff;
      elp_vld_in  = elp_vld_ff;
      cs_err_in   = cs_err_ff;
      rb_err_in   = rb_err_ff;
      to_err_in   = to_err_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff;

      tbl_we    = 1'b0;
      tbl_waddr = sel_ff;
      tbl_wdata = ROW_W'(act_row);
      tbl_raddr = (phase_ff == PH_SWEEP) ? rd_cnt_ff[IW-1:0] : sel_ff;
      elp_we    = 1'b0;
      elp_waddr = proc_idx_ff;
      elp_wdata = pick_per ? 16'd0 : p_inc;
      elp_raddr = rd_cnt_ff[IW-1:0];

      // configuration: the user must write it only while idle; the block does not enforce this
      if (csr_we) begin
         case (csr_addr)
            CSR_ENHANCED:  cfg_in.enhanced  = csr_wdata[0];
            CSR_TO_TWO:    cfg_in.to_two    = csr_wdata;
            CSR_TO_FOUR:   cfg_in.to_four   = csr_wdata;
            CSR_TO_EIGHT:  cfg_in.to_eight  = csr_wdata;
            CSR_SLEEP:     cfg_in.sleep     = csr_wdata;
            CSR_WAKE_WAIT: cfg_in.wake_wait = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_tvalid) begin
               req_in   = req_type'(req_tdata[$bits(req_type)-1:0]);
               op_in    = req_tuser;
               phase_in = PH_OP;
            end
         end
         PH_OP: begin
            if (idx_ok && op_ff == OP_WRITE) begin
               tbl_we              = 1'b1;
               tbl_waddr           = req_idx;
               tbl_wdata           = ROW_W'(new_row);
               tbl_vld_in[req_idx] = 1'b1;
            end
            if (idx_ok && op_ff == OP_FORCE) force_in[req_idx] = 1'b1;
            if (req_ff.tick && ctx_ff.st_elapsed != TICK_MAX) begin
               ctx_in.st_elapsed = ctx_ff.st_elapsed + 16'd1;
            end
            if (req_ff.rx_valid) begin
               ctx_in.pend_flag = 1'b1;
               ctx_in.pend_val  = req_ff.rx_byte;
            end
            found_in    = 1'b0;
            rd_cnt_in   = '0;
            proc_vld_in = 1'b0;
            // without a tick and outside home the sweep changes nothing
            phase_in    = (req_ff.tick || ctx_ff.state == ST_HOME) ? PH_SWEEP : PH_RD;
         end
         PH_SWEEP: begin
            proc_vld_in = issue;
            proc_idx_in = rd_cnt_ff[IW-1:0];
            if (issue) rd_cnt_in = rd_cnt_ff + CW'(1);
            if (proc_vld_ff) begin
               elp_we                  = 1'b1;
               elp_vld_in[proc_idx_ff] = 1'b1;
               if (pick_force) force_in[proc_idx_ff] = 1'b0;
               if (pick_force || pick_per) begin
                  found_in    = 1'b1;
                  sel_in      = proc_idx_ff;
                  ctx_in.alen = frame_len(p_row.id, p_row.len);
               end
            end
            if (!issue && !proc_vld_ff) phase_in = PH_RD;
         end
         PH_RD: begin
            phase_in = PH_EXEC;
         end
         PH_EXEC: begin
            if (!rsp_vld_ff || rsp_tready) begin
               ctx_in = step.nxt;
               if (step.ev == EV_CS_FAIL) cs_err_in = cs_err_ff + 16'd1;
               if (step.ev == EV_RB_FAIL) rb_err_in = rb_err_ff + 16'd1;
               if (step.ev == EV_TIMEOUT) to_err_in = to_err_ff + 16'd1;
               if (step.row_we) begin
                  // received byte lands in the active entry's data
                  tbl_we             = 1'b1;
                  tbl_waddr          = sel_ff;
                  tbl_wdata          = ROW_W'({step.row_data, act_row.period, act_row.len,
                                               act_row.is_tx, act_row.id});
                  tbl_vld_in[sel_ff] = 1'b1;
               end
               rsp_in.tx_valid        = step.tx_valid;
               rsp_in.tx_is_break     = step.tx_brk;
               rsp_in.tx_byte         = step.tx_byte;
               rsp_in.machine_state   = step.nxt.state;
               rsp_in.event_code      = step.ev;
               rsp_in.event_frame     = (step.ev != EV_NONE) ? 3'(sel_ff) : 3'd0;
               rsp_in.rx_frame_data   = step.rx_data;
               rsp_in.checksum_errors = cs_err_in;
               rsp_in.readback_errors = rb_err_in;
               rsp_in.timing_errors   = to_err_in;
               rsp_vld_in             = 1'b1;
               phase_in               = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         cfg_ff.enhanced    <= 1'b1;
         cfg_ff.to_two      <= 16'd10;
         cfg_ff.to_four     <= 16'd15;
         cfg_ff.to_eight    <= 16'd20;
         cfg_ff.sleep       <= 16'd4000;
         cfg_ff.wake_wait   <= 16'd100;
         // all zero: state and return state are home
         ctx_ff             <= '0;
         sel_ff             <= '0;
         found_ff           <= 1'b0;
         rd_cnt_ff          <= '0;
         proc_vld_ff        <= 1'b0;
         force_ff           <= '0;
         tbl_vld_ff         <= '0;
         elp_vld_ff         <= '0;
         cs_err_ff          <= '0;
         rb_err_ff          <= '0;
         to_err_ff          <= '0;
         rsp_vld_ff         <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cfg_ff      <= cfg_in;
         ctx_ff      <= ctx_in;
         sel_ff      <= sel_in;
         found_ff    <= found_in;
         rd_cnt_ff   <= rd_cnt_in;
         proc_vld_ff <= proc_vld_in;
         force_ff    <= force_in;
         tbl_vld_ff  <= tbl_vld_in;
         elp_vld_ff  <= elp_vld_in;
         cs_err_ff   <= cs_err_in;
         rb_err_ff   <= rb_err_in;
         to_err_ff   <= to_err_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      op_ff       <= op_in;
      proc_idx_ff <= proc_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign req_tready = (phase_ff == PH_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_W - $bits(rsp_type))'(0), rsp_ff};

endmodule

>>> rtl/lmfe_checker.sv
module lmfe_checker import lmfe_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // any frame event returns the engine home
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16:14] != EV_NONE |-> rsp_tdata[13:10] == ST_HOME)
      else $error("event without return to home");

   // break carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && rsp_tdata[9:2] == 8'd0)
      else $error("malformed break");

   // received data only shows on a finished frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[83:20] != 64'd0 |-> rsp_tdata[16:14] == EV_DONE)
      else $error("rx data outside frame done");

   // every transmission is followed by readback or the wake-up wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[13:10] == ST_READBACK || rsp_tdata[13:10] == ST_WAKE_WAIT)
      else $error("transmit without readback state");

endmodule

bind lin_master_frame_engine lmfe_checker u_lmfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
